// ----- design/les_pkg.sv -----
// Package for the LED effect sequencer: payload structs, opcodes, effect ROM.
// No dependencies.
`timescale 1ns / 1ps
package les_pkg;

    typedef struct packed {
        logic        req_type;
        logic [1:0]  channel;
        logic [2:0]  effect;
        logic [15:0] count;
        logic [7:0]  restore_level;
        logic        restore_is_zcl;
    } les_in_t;

    typedef struct packed {
        logic [1:0] out_channel;
        logic [7:0] level;
        logic       level_is_zcl;
        logic       last;
    } les_out_t;

    typedef enum logic [1:0] {
        OP_END   = 2'd0,
        OP_DELAY = 2'd1,
        OP_LEVEL = 2'd2,
        OP_RAMP  = 2'd3
    } les_op_t;

    typedef struct packed {
        les_op_t    op;
        logic [6:0] a;
        logic [6:0] b;
        logic [4:0] n;
    } les_instr_t;

    localparam int unsigned NUM_EFFECTS = 6;
    localparam int unsigned MAX_RES     = 8;
    localparam int unsigned STEP_GUARD  = 16;
    localparam int unsigned TICKS_PER_S = 1000 / 50;
    localparam logic [4:0] T500 = 5'((500 * TICKS_PER_S) / 1000);
    localparam logic [4:0] T250 = 5'((250 * TICKS_PER_S) / 1000);
    localparam logic [4:0] T150 = 5'((150 * TICKS_PER_S) / 1000);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TICK_CH,
        ST_STEP,
        ST_DIV,
        ST_RAMP_OUT,
        ST_EMIT,
        ST_FINISH
    } les_state_t;

    function automatic les_instr_t rom_read(input logic [2:0] e, input logic [2:0] ix);
        les_instr_t r;
        r = '{OP_END, 7'd0, 7'd0, 5'd0};
        case (e)
            3'd1:
                case (ix)
                    3'd0: r = '{OP_RAMP, 7'd1, 7'd100, T500};
                    3'd1: r = '{OP_RAMP, 7'd99, 7'd0, T500};
                    default: r = '{OP_END, 7'd0, 7'd0, 5'd0};
                endcase
            3'd2:
                case (ix)
                    3'd0: r = '{OP_LEVEL, 7'd50, 7'd0, 5'd0};
                    3'd1: r = '{OP_DELAY, 7'd0, 7'd0, T250};
                    3'd2: r = '{OP_LEVEL, 7'd0, 7'd0, 5'd0};
                    3'd3: r = '{OP_DELAY, 7'd0, 7'd0, T250};
                    default: r = '{OP_END, 7'd0, 7'd0, 5'd0};
                endcase
            3'd3:
                case (ix)
                    3'd0: r = '{OP_LEVEL, 7'd50, 7'd0, 5'd0};
                    3'd1: r = '{OP_DELAY, 7'd0, 7'd0, T150};
                    3'd2: r = '{OP_LEVEL, 7'd50, 7'd0, 5'd0};
                    3'd3: r = '{OP_DELAY, 7'd0, 7'd0, T150};
                    3'd4: r = '{OP_LEVEL, 7'd0, 7'd0, 5'd0};
                    3'd5: r = '{OP_DELAY, 7'd0, 7'd0, T150};
                    default: r = '{OP_END, 7'd0, 7'd0, 5'd0};
                endcase
            3'd4:
                case (ix)
                    3'd0: r = '{OP_LEVEL, 7'd100, 7'd0, 5'd0};
                    3'd1: r = '{OP_DELAY, 7'd0, 7'd0, T500};
                    3'd2: r = '{OP_LEVEL, 7'd0, 7'd0, 5'd0};
                    3'd3: r = '{OP_DELAY, 7'd0, 7'd0, T500};
                    default: r = '{OP_END, 7'd0, 7'd0, 5'd0};
                endcase
            3'd5:
                case (ix)
                    3'd0: r = '{OP_RAMP, 7'd1, 7'd100, T150};
                    3'd1: r = '{OP_RAMP, 7'd99, 7'd0, T150};
                    default: r = '{OP_END, 7'd0, 7'd0, 5'd0};
                endcase
            default: r = '{OP_END, 7'd0, 7'd0, 5'd0};
        endcase
        return r;
    endfunction

endpackage

// ----- design/led_effect_sequencer_core.sv -----
// LED effect sequencer top level: per-channel state, sequencer, output register.
// Depends on les_pkg and les_divider.
`timescale 1ns / 1ps
//
//  channel | dir | payload              | beat
//  in      | in  | les_pkg::les_in_t    | in_valid & in_ready
//  out     | out | les_pkg::les_out_t   | out_valid & out_ready
//
//  A tick visits each channel in turn and a command only its own channel;
//  instructions are stepped one at a time, and each ramp step goes through
//  the shared serial divider. Each level update waits in the output register
//  until taken; a stalled sink holds the sequencer. The block takes no new
//  beat until the last result of the current one is placed in the output
//  register. Reset clears all channel state at once.
module led_effect_sequencer_core #(
    parameter int unsigned CHANNELS = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  les_pkg::les_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output les_pkg::les_out_t out_data
);
    import les_pkg::*;

    localparam int unsigned CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // channel addressed by the incoming command, sized to the channel index
    logic [CW-1:0] cmd_ch;
    assign cmd_ch = CW'(in_data.channel);

    // per-channel state
    logic        running_reg   [CHANNELS];
    logic [2:0]  cur_eff_reg   [CHANNELS];
    logic [2:0]  ix_reg        [CHANNELS];
    logic        begun_reg     [CHANNELS];
    logic [9:0]  step_reg      [CHANNELS];
    logic [7:0]  wait_reg      [CHANNELS];
    logic [2:0]  forever_reg   [CHANNELS];
    logic [2:0]  repeat_reg    [CHANNELS];
    logic [15:0] left_reg      [CHANNELS];

    les_state_t  state_reg, state_next;
    les_in_t     req_reg;
    logic [CW:0] ch_reg, ch_next;      // wide enough to hold CHANNELS
    logic [4:0]  guard_reg, guard_next;
    logic [3:0]  nres_reg, nres_next;
    les_out_t    obuf_reg;
    logic        obuf_valid_reg;
    logic [7:0]  pend_level_reg, pend_level_next;
    logic        pend_zcl_reg, pend_zcl_next;
    les_state_t  ret_reg, ret_next;    // state after emit

    logic [CW-1:0] ci;
    assign ci = ch_reg[CW-1:0];

    les_instr_t ins;
    assign ins = rom_read(cur_eff_reg[ci], ix_reg[ci]);

    // interpolation numerator: 100*(a*(T-t) + b*t), t clamped to T
    logic [4:0]  t_cl;
    logic [4:0]  t_rem;
    logic [12:0] mix;
    logic [19:0] num;
    logic        div_start, div_done;
    logic [19:0] div_q;
    logic [19:0] quo_reg;
    logic [7:0]  lvl_calc;

    assign t_cl  = (step_reg[ci] > {5'd0, ins.n}) ? ins.n : step_reg[ci][4:0];
    assign t_rem = ins.n - t_cl;
    assign mix   = ({6'd0, ins.a} * {8'd0, t_rem}) + ({6'd0, ins.b} * {8'd0, t_cl});
    assign num   = {7'd0, mix} * 20'd100;

    les_divider u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(num),
        .divisor (ins.n),
        .done    (div_done),
        .quotient(div_q)
    );

    // (q + 50) / 100 for q <= 12700, by reciprocal: x*5243 >> 19
    logic [19:0] qp;
    logic [27:0] prod;
    assign qp       = quo_reg + 20'd50;
    assign prod     = 28'(qp) * 28'd5243;
    assign lvl_calc = prod[26:19];

    logic is_cmd;
    assign is_cmd = req_reg.req_type;

    // channel state update controls
    logic fin_emit;
    logic out_take;
    assign out_take = out_valid && out_ready;

    always_comb
    begin
        state_next      = state_reg;
        ch_next         = ch_reg;
        guard_next      = guard_reg;
        nres_next       = nres_reg;
        pend_level_next = pend_level_reg;
        pend_zcl_next   = pend_zcl_reg;
        ret_next        = ret_reg;
        div_start       = 1'b0;
        fin_emit        = 1'b0;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                begin
                    ch_next    = in_data.req_type ? {1'b0, cmd_ch} : '0;
                    guard_next = '0;
                    nres_next  = '0;
                    state_next = in_data.req_type ? ST_STEP : ST_TICK_CH;
                end
            ST_TICK_CH:
                if (ch_reg >= (CW+1)'(CHANNELS))
                    state_next = ST_FINISH;
                else
                begin
                    guard_next = '0;
                    if (running_reg[ci] && wait_reg[ci] <= 8'd1)
                        state_next = ST_STEP;
                    else
                        ch_next = ch_reg + 1'b1;
                end
            ST_STEP:
                if (!running_reg[ci] || guard_reg == 5'(STEP_GUARD) || state_reg != ST_STEP)
                    state_next = ST_FINISH;
                else
                begin
                    guard_next = guard_reg + 5'd1;
                    case (ins.op)
                        OP_LEVEL:
                        begin
                            pend_level_next = {1'b0, ins.a};
                            pend_zcl_next   = 1'b0;
                            ret_next        = ST_STEP;
                            state_next      = ST_EMIT;
                        end
                        OP_RAMP:
                            if (!begun_reg[ci])
                            begin
                                pend_level_next = {1'b0, ins.a};
                                pend_zcl_next   = 1'b0;
                                ret_next        = ST_FINISH;
                                state_next      = ST_EMIT;
                            end
                            else if (ins.n == 5'd0)
                            begin
                                pend_level_next = {1'b0, ins.b};
                                pend_zcl_next   = 1'b0;
                                ret_next        = ST_STEP;
                                state_next      = ST_EMIT;
                            end
                            else
                            begin
                                div_start  = 1'b1;
                                state_next = ST_DIV;
                            end
                        OP_DELAY:
                            if (ins.n != 5'd0)
                                state_next = ST_FINISH;
                        default:
                            if (left_reg[ci] <= 16'd1 && forever_reg[ci] == 3'd0)
                                state_next = ST_FINISH;
                    endcase
                end
            ST_DIV:
                if (div_done)
                    state_next = ST_RAMP_OUT;
            ST_RAMP_OUT:
            begin
                pend_level_next = lvl_calc;
                pend_zcl_next   = 1'b0;
                ret_next        = (lvl_calc == {1'b0, ins.b}) ? ST_STEP : ST_FINISH;
                state_next      = ST_EMIT;
            end
            ST_EMIT:
                if (!obuf_valid_reg || out_take)
                begin
                    fin_emit   = 1'b1;
                    if (nres_reg != 4'(MAX_RES))
                        nres_next = nres_reg + 4'd1;
                    state_next = ret_reg;
                end
            ST_FINISH:
                // end of one channel's run
                if (!is_cmd && ch_reg < (CW+1)'(CHANNELS))
                begin
                    ch_next    = ch_reg + 1'b1;
                    state_next = ST_TICK_CH;
                end
                else if (!obuf_valid_reg || out_take)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // commands set channel state in ST_IDLE on accept; starts step via ST_STEP, stop emits via ST_EMIT
    logic cmd_ok, stop_act;
    assign cmd_ok   = in_data.req_type && (32'(in_data.channel) < CHANNELS)
                    && (in_data.effect < 3'(NUM_EFFECTS));
    assign stop_act = cmd_ok && in_data.effect == 3'd0
                    && (forever_reg[cmd_ch] != 3'd0
                        || repeat_reg[cmd_ch] != 3'd0);
    logic [7:0] rl_sat;
    always_comb
    begin
        rl_sat = in_data.restore_level;
        if (in_data.restore_is_zcl)
        begin
            if (rl_sat > 8'd254)
                rl_sat = 8'd254;
        end
        else if (rl_sat > 8'd100)
            rl_sat = 8'd100;
    end

    // input handshake: ready only in ST_IDLE
    logic        accept;
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    les_state_t st_eff;  // effective next state incl. command routing
    always_comb
    begin
        st_eff = state_next;
        if (accept && in_data.req_type)
        begin
            if (!cmd_ok)
                st_eff = ST_IDLE;
            else if (in_data.effect == 3'd0)
                st_eff = stop_act ? ST_EMIT : ST_IDLE;
        end
    end

    // output register: results are held one behind so 'last' is known
    logic        hold_valid_reg;
    les_out_t    hold_reg;
    logic        push;
    les_out_t    push_data;
    assign push      = fin_emit && (nres_reg != 4'(MAX_RES));
    assign push_data = '{out_channel: 2'(ci), level: pend_level_reg,
                         level_is_zcl: pend_zcl_reg, last: 1'b0};

    // finishing flush: beat done when going back to idle
    logic flush;
    assign flush = (state_reg != ST_IDLE) && (state_next == ST_IDLE)
                && (state_reg == ST_FINISH || state_reg == ST_EMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ch_reg         <= '0;
            guard_reg      <= '0;
            nres_reg       <= '0;
            obuf_valid_reg <= 1'b0;
            hold_valid_reg <= 1'b0;
            ret_reg        <= ST_IDLE;
            for (int i = 0; i < CHANNELS; i++)
            begin
                running_reg[i] <= 1'b0;
                cur_eff_reg[i] <= '0;
                ix_reg[i]      <= '0;
                begun_reg[i]   <= 1'b0;
                step_reg[i]    <= '0;
                wait_reg[i]    <= '0;
                forever_reg[i] <= '0;
                repeat_reg[i]  <= '0;
                left_reg[i]    <= '0;
            end
        end
        else
        begin
            state_reg <= st_eff;
            ch_reg    <= ch_next;
            guard_reg <= guard_next;
            nres_reg  <= nres_next;
            ret_reg   <= (accept && stop_act) ? ST_FINISH : ret_next;

            // output path: hold stage feeds output register
            if (push)
                hold_valid_reg <= 1'b1;
            else if (flush && hold_valid_reg)
                hold_valid_reg <= 1'b0;
            if ((push || flush) && hold_valid_reg)
                obuf_valid_reg <= 1'b1;
            else if (out_take)
                obuf_valid_reg <= 1'b0;

            // command start / stop
            if (accept && cmd_ok)
            begin
                if (in_data.effect == 3'd0)
                begin
                    if (stop_act)
                    begin
                        forever_reg[cmd_ch] <= '0;
                        repeat_reg[cmd_ch]  <= '0;
                        left_reg[cmd_ch]    <= '0;
                        running_reg[cmd_ch] <= 1'b0;
                        wait_reg[cmd_ch]    <= '0;
                    end
                end
                else
                begin
                    left_reg[cmd_ch] <= in_data.count;
                    if (in_data.count == 16'd0)
                        forever_reg[cmd_ch] <= in_data.effect;
                    else
                        repeat_reg[cmd_ch] <= in_data.effect;
                    cur_eff_reg[cmd_ch] <= in_data.effect;
                    ix_reg[cmd_ch]      <= '0;
                    begun_reg[cmd_ch]   <= 1'b0;
                    step_reg[cmd_ch]    <= '0;
                    wait_reg[cmd_ch]    <= '0;
                    running_reg[cmd_ch] <= 1'b1;
                end
            end

            if (state_reg == ST_TICK_CH && ch_reg < (CW+1)'(CHANNELS)
                && running_reg[ci] && wait_reg[ci] != 8'd0)
                wait_reg[ci] <= wait_reg[ci] - 8'd1;

            // guard exhaustion leaves a one-tick wait
            if (state_reg == ST_STEP && running_reg[ci] && guard_reg == 5'(STEP_GUARD))
                wait_reg[ci] <= 8'd1;

            if (state_reg == ST_STEP && running_reg[ci] && guard_reg != 5'(STEP_GUARD))
            begin
                case (ins.op)
                    OP_DELAY:
                    begin
                        wait_reg[ci]  <= {3'd0, ins.n};
                        ix_reg[ci]    <= ix_reg[ci] + 3'd1;
                        begun_reg[ci] <= 1'b0;
                        step_reg[ci]  <= '0;
                    end
                    OP_LEVEL:
                    begin
                        ix_reg[ci]    <= ix_reg[ci] + 3'd1;
                        begun_reg[ci] <= 1'b0;
                        step_reg[ci]  <= '0;
                    end
                    OP_RAMP:
                        if (!begun_reg[ci])
                        begin
                            begun_reg[ci] <= 1'b1;
                            wait_reg[ci]  <= 8'd1;
                        end
                        else if (ins.n == 5'd0)
                        begin
                            // zero-tick ramp lands on its stop level
                            ix_reg[ci]    <= ix_reg[ci] + 3'd1;
                            begun_reg[ci] <= 1'b0;
                            step_reg[ci]  <= '0;
                        end
                    default:
                    begin
                        ix_reg[ci]    <= '0;
                        begun_reg[ci] <= 1'b0;
                        step_reg[ci]  <= '0;
                        if (left_reg[ci] != 16'd0)
                            left_reg[ci] <= left_reg[ci] - 16'd1;
                        if (left_reg[ci] > 16'd1)
                        begin
                            cur_eff_reg[ci] <= repeat_reg[ci];
                            wait_reg[ci]    <= '0;
                        end
                        else if (forever_reg[ci] != 3'd0)
                        begin
                            cur_eff_reg[ci] <= forever_reg[ci];
                            wait_reg[ci]    <= '0;
                        end
                        else
                            running_reg[ci] <= 1'b0;
                    end
                endcase
            end

            if (state_reg == ST_RAMP_OUT)
            begin
                if (lvl_calc == {1'b0, ins.b})
                begin
                    ix_reg[ci]    <= ix_reg[ci] + 3'd1;
                    begun_reg[ci] <= 1'b0;
                    step_reg[ci]  <= '0;
                end
                else
                begin
                    if (step_reg[ci] < 10'd1023)
                        step_reg[ci] <= step_reg[ci] + 10'd1;
                    wait_reg[ci] <= 8'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_done)
            quo_reg <= div_q;
        if (accept && stop_act)
        begin
            pend_level_reg <= rl_sat;
            pend_zcl_reg   <= in_data.restore_is_zcl;
        end
        else
        begin
            pend_level_reg <= pend_level_next;
            pend_zcl_reg   <= pend_zcl_next;
        end
        if (accept)
            req_reg <= in_data;
        if (push)
        begin
            hold_reg <= push_data;
            if (hold_valid_reg)
                obuf_reg <= hold_reg;
        end
        else if (flush && hold_valid_reg)
            obuf_reg <= '{out_channel: hold_reg.out_channel, level: hold_reg.level,
                          level_is_zcl: hold_reg.level_is_zcl, last: 1'b1};
    end

    assign out_valid = obuf_valid_reg;
    assign out_data  = obuf_reg;

`ifndef SYNTHESIS
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !hold_valid_reg)
        else $error("held result left at idle");
    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        nres_reg <= 4'(MAX_RES))
        else $error("result count overflow");
    a_guard: assert property (@(posedge clk) disable iff (!rst_n)
        guard_reg <= 5'(STEP_GUARD))
        else $error("guard overrun");
`endif
endmodule

// ----- design/les_divider.sv -----
// Restoring divider, one quotient bit a cycle, unsigned 20-bit / 5-bit.
// Depends on nothing beyond the clock and reset.
`timescale 1ns / 1ps
module les_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [19:0] dividend,
    input  logic [4:0]  divisor,
    output logic        done,
    output logic [19:0] quotient
);
    logic [19:0] quo_reg, quo_next;
    logic [4:0]  rem_reg, rem_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [5:0]  trial;
    logic [5:0]  diff;

    assign trial = {rem_reg, quo_reg[19]};
    assign diff  = trial - {1'b0, divisor};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = 5'd20;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_next = diff[4:0];
                quo_next = {quo_reg[18:0], 1'b1};
            end
            else
            begin
                rem_next = trial[4:0];
                quo_next = {quo_reg[18:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done     = busy_reg && (cnt_reg == 5'd1);
    assign quotient = quo_next;

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && (cnt_reg != 5'd1) |-> !start)
        else $error("divider restarted while busy");
    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("divider done held");
    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (cnt_reg == 5'd0 || cnt_reg == 5'd1))
        else $error("divider count stray");
`endif
endmodule

// ----- dv/led_effect_sequencer_core_tb.sv -----
// Testbench for led_effect_sequencer_core: directed and random commands and ticks,
// checked against a behavioural model of the per-channel effect interpreter.
// Depends on les_pkg and the design under design/.
`timescale 1ns / 1ps
module led_effect_sequencer_core_tb;
    import les_pkg::*;

    localparam int NCH = 4;
    localparam int STALL_LIMIT = 20000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    les_in_t   in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    les_out_t  out_data;

    led_effect_sequencer_core #(.CHANNELS(NCH)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    always #2 clk = ~clk;

    // Shadow channel state
    logic        ch_run     [NCH];
    logic [2:0]  ch_eff     [NCH];
    logic [2:0]  ch_ix      [NCH];
    logic        ch_rbegun  [NCH];
    logic [9:0]  ch_rstep   [NCH];
    logic [7:0]  ch_wait    [NCH];
    logic [2:0]  ch_forever [NCH];
    logic [2:0]  ch_repeat  [NCH];
    logic [15:0] ch_reps    [NCH];

    les_out_t level_q[$];   // expected level updates, oldest first
    les_out_t beat_buf[$];  // updates caused by the beat being modelled
    int n_fail = 0;
    int n_items = 0;
    int n_results = 0;
    int idle_cycles = 0;

    function automatic void push_level(int ch, int lvl, bit zcl);
        les_out_t r;
        if (beat_buf.size() >= MAX_RES)
            return;
        r.out_channel = ch[1:0];
        r.level = lvl[7:0];
        r.level_is_zcl = zcl;
        r.last = 1'b0;
        beat_buf.push_back(r);
    endfunction

    function automatic void clear_ramp(int ch);
        ch_rbegun[ch] = 1'b0;
        ch_rstep[ch] = '0;
    endfunction

    function automatic void launch(int ch, logic [2:0] e);
        ch_eff[ch] = e;
        ch_ix[ch] = '0;
        clear_ramp(ch);
        ch_wait[ch] = '0;
        ch_run[ch] = 1'b1;
    endfunction

    // Rounded linear interpolation between two percent levels
    function automatic int ramp_level(int a, int b, int span, int t);
        int s, e;
        s = a * 100;
        e = b * 100;
        if (t > span)
            t = span;
        return (((e - s) * t + s * span) / span + 50) / 100;
    endfunction

    // Own copy of the effect programs
    function automatic les_instr_t program_word(logic [2:0] e, logic [2:0] ix);
        les_instr_t w;
        w = '{OP_END, 7'd0, 7'd0, 5'd0};
        case (e)
            3'd1, 3'd5:
            begin
                if (ix == 3'd0)
                    w = '{OP_RAMP, 7'd1, 7'd100, (e == 3'd1) ? 5'd10 : 5'd3};
                else if (ix == 3'd1)
                    w = '{OP_RAMP, 7'd99, 7'd0, (e == 3'd1) ? 5'd10 : 5'd3};
            end
            3'd2, 3'd4:
            begin
                if (ix == 3'd0)
                    w = '{OP_LEVEL, (e == 3'd2) ? 7'd50 : 7'd100, 7'd0, 5'd0};
                else if (ix == 3'd2)
                    w = '{OP_LEVEL, 7'd0, 7'd0, 5'd0};
                else if (ix == 3'd1 || ix == 3'd3)
                    w = '{OP_DELAY, 7'd0, 7'd0, (e == 3'd2) ? 5'd5 : 5'd10};
            end
            3'd3:
            begin
                if (ix == 3'd0 || ix == 3'd2)
                    w = '{OP_LEVEL, 7'd50, 7'd0, 5'd0};
                else if (ix == 3'd4)
                    w = '{OP_LEVEL, 7'd0, 7'd0, 5'd0};
                else if (ix == 3'd1 || ix == 3'd3 || ix == 3'd5)
                    w = '{OP_DELAY, 7'd0, 7'd0, 5'd3};
            end
            default: ;
        endcase
        return w;
    endfunction

    function automatic void advance_channel(int ch);
        les_instr_t w;
        int lvl;
        for (int g = 0; g < STEP_GUARD; g++)
        begin
            if (!ch_run[ch])
                return;
            w = program_word(ch_eff[ch], ch_ix[ch]);
            case (w.op)
                OP_DELAY:
                begin
                    ch_wait[ch] = 8'(w.n);
                    ch_ix[ch] = ch_ix[ch] + 3'd1;
                    clear_ramp(ch);
                    if (w.n != 0)
                        return;
                end
                OP_LEVEL:
                begin
                    push_level(ch, w.a, 1'b0);
                    ch_ix[ch] = ch_ix[ch] + 3'd1;
                    clear_ramp(ch);
                end
                OP_RAMP:
                begin
                    if (!ch_rbegun[ch])
                    begin
                        ch_rbegun[ch] = 1'b1;
                        push_level(ch, w.a, 1'b0);
                        ch_wait[ch] = 8'd1;
                        return;
                    end
                    if (w.n == 0)
                        lvl = w.b;
                    else
                        lvl = ramp_level(w.a, w.b, w.n, ch_rstep[ch]);
                    if (ch_rstep[ch] < 10'd1023)
                        ch_rstep[ch] = ch_rstep[ch] + 10'd1;
                    push_level(ch, lvl, 1'b0);
                    if (lvl == int'(w.b))
                    begin
                        ch_ix[ch] = ch_ix[ch] + 3'd1;
                        clear_ramp(ch);
                    end
                    else
                    begin
                        ch_wait[ch] = 8'd1;
                        return;
                    end
                end
                default:
                begin
                    // end of program: repeat, fall back or stop
                    ch_ix[ch] = '0;
                    clear_ramp(ch);
                    if (ch_reps[ch] > 0)
                        ch_reps[ch]--;
                    if (ch_reps[ch] > 0)
                        launch(ch, ch_repeat[ch]);
                    else if (ch_forever[ch] != 0)
                        launch(ch, ch_forever[ch]);
                    else
                    begin
                        ch_run[ch] = 1'b0;
                        return;
                    end
                end
            endcase
        end
        ch_wait[ch] = 8'd1;
    endfunction

    function automatic void predict_levels(les_in_t b);
        int ch;
        int rl;
        ch = b.channel;
        beat_buf.delete();
        if (!b.req_type)
        begin
            for (int c = 0; c < NCH; c++)
            begin
                if (!ch_run[c])
                    continue;
                if (ch_wait[c] > 0)
                    ch_wait[c]--;
                if (ch_wait[c] == 0)
                    advance_channel(c);
            end
        end
        else if (ch < NCH && b.effect < NUM_EFFECTS)
        begin
            if (b.effect == 3'd0)
            begin
                if (ch_forever[ch] != 0 || ch_repeat[ch] != 0)
                begin
                    rl = b.restore_level;
                    if (b.restore_is_zcl)
                        rl = (rl > 254) ? 254 : rl;
                    else
                        rl = (rl > 100) ? 100 : rl;
                    push_level(ch, rl, b.restore_is_zcl);
                    ch_forever[ch] = '0;
                    ch_repeat[ch] = '0;
                    ch_reps[ch] = '0;
                    ch_run[ch] = 1'b0;
                    ch_wait[ch] = '0;
                end
            end
            else
            begin
                ch_reps[ch] = b.count;
                if (b.count == 0)
                    ch_forever[ch] = b.effect;
                else
                    ch_repeat[ch] = b.effect;
                launch(ch, b.effect);
                advance_channel(ch);
            end
        end
        if (beat_buf.size() > 0)
            beat_buf[beat_buf.size() - 1].last = 1'b1;
        foreach (beat_buf[i])
            level_q.push_back(beat_buf[i]);
    endfunction

    // Sends one beat after a random gap; the model is updated on acceptance.
    // Valid is left high after acceptance; the next call drops it before a nonzero gap, and a drain drops it.
    task automatic send_beat(les_in_t b);
        int gap;
        gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= b;
        do
            @(posedge clk);
        while (!in_ready);
        predict_levels(b);
        n_items++;
    endtask

    function automatic les_in_t tick_beat();
        les_in_t b;
        b = '0;
        b.channel = 2'($urandom);
        b.effect = 3'($urandom);
        b.count = 16'($urandom);
        b.restore_level = 8'($urandom);
        b.restore_is_zcl = 1'($urandom);
        return b;
    endfunction

    function automatic les_in_t run_beat(int ch, int e, int cnt, int rl, bit zcl);
        les_in_t b;
        b.req_type = 1'b1;
        b.channel = ch[1:0];
        b.effect = e[2:0];
        b.count = cnt[15:0];
        b.restore_level = rl[7:0];
        b.restore_is_zcl = zcl;
        return b;
    endfunction

    task automatic send_ticks(int n);
        for (int i = 0; i < n; i++)
            send_beat(tick_beat());
    endtask

    task automatic drain_levels();
        in_valid <= 1'b0;
        while (level_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Sink: random stall per beat, compares each level update in order
    initial
    begin
        les_out_t exp_lvl;
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = $urandom_range(0, 7);
            if ($urandom_range(0, 3) == 0)
                stall = 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            n_results++;
            if (level_q.size() == 0)
            begin
                n_fail++;
                if (n_fail <= 10)
                    $display("ERROR: unexpected level update %p", out_data);
            end
            else
            begin
                exp_lvl = level_q.pop_front();
                if (out_data !== exp_lvl)
                begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("ERROR: level update mismatch exp %p got %p",
                                 exp_lvl, out_data);
                end
            end
        end
    end

    // Watchdog on cycles without any beat moving
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("led_effect_sequencer_core verification failed");
            $finish;
        end
    end

    // Every effect, each on one channel, finite and forever, ticked through
    task automatic test_each_effect();
        for (int e = 1; e < 6; e++)
        begin
            send_beat(run_beat(e % NCH, e, (e == 3) ? 2 : 0, 0, 1'b0));
        end
        send_ticks(12);
    endtask

    // Stops with restore saturation, stop with nothing set, bad effects
    task automatic test_stop_and_bad();
        send_beat(run_beat(0, 0, 0, 255, 1'b1));
        send_beat(run_beat(1, 0, 0, 200, 1'b0));
        send_beat(run_beat(2, 0, 0, 100, 1'b0));
        send_beat(run_beat(1, 0, 0, 7, 1'b1));      // nothing active
        send_beat(run_beat(3, 6, 5, 0, 1'b0));
        send_beat(run_beat(3, 7, 65535, 0, 1'b0));
        send_beat(run_beat(3, 4, 65535, 254, 1'b1));
        send_beat(run_beat(0, 2, 1, 0, 1'b0));      // finite only, then stops
        send_ticks(3);
    endtask

    // Sender holds off until every outstanding update has drained
    task automatic test_drain_pause();
        drain_levels();
        send_ticks(2);
    endtask

    task automatic test_random_traffic(int n);
        int ch;
        for (int i = 0; i < n; i++)
        begin
            ch = $urandom_range(0, 3);
            case ($urandom_range(0, 9))
                0, 1: send_beat(run_beat(ch, $urandom_range(1, 5),
                          ($urandom_range(0, 1)) ? 0 : $urandom_range(1, 3), 0, 1'b0));
                2: send_beat(run_beat(ch, 0, 0, $urandom_range(0, 255), 1'($urandom)));
                3: send_beat(run_beat(ch, $urandom_range(0, 7), $urandom_range(0, 65535),
                          $urandom_range(0, 255), 1'($urandom)));
                default: send_beat(tick_beat());
            endcase
        end
    endtask

    initial
    begin
        for (int c = 0; c < NCH; c++)
        begin
            ch_run[c] = 1'b0; ch_eff[c] = '0; ch_ix[c] = '0; ch_rbegun[c] = 1'b0;
            ch_rstep[c] = '0; ch_wait[c] = '0; ch_forever[c] = '0;
            ch_repeat[c] = '0; ch_reps[c] = '0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_each_effect();
        test_stop_and_bad();
        test_drain_pause();
        test_random_traffic(230);
        drain_levels();
        $display("Covered %0d beats in, %0d level updates out: all effects, stops,",
                 n_items, n_results);
        $display("restore saturation, ignored commands and random traffic.");
        if (n_fail == 0)
            $display("led_effect_sequencer_core verification clean");
        else
            $display("led_effect_sequencer_core verification failed");
        $finish;
    end
endmodule
